>>> rtl/cti_pkg.sv
`default_nettype none
package cti_pkg;
    localparam int CAL_POINTS_DEF = 9;
    localparam int VALUE_W = 12;
    localparam int INDEX_W = 4;
    localparam int FLOW_W = 5;
    localparam int STATUS_W = 2;
    localparam int FLOW_OFFSET = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSIDE = 2'd0,
        ST_BELOW  = 2'd1,
        ST_ABOVE  = 2'd2
    } t_status;

    typedef struct packed {
        logic               is_write;
        logic [INDEX_W-1:0] point_index;
        logic [VALUE_W-1:0] value;
    } t_cmd;
endpackage
`default_nettype wire

>>> rtl/cti_front.sv
`default_nettype none
module cti_front
    import cti_pkg::*;
#(
    parameter int CAL_POINTS = CAL_POINTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_kind,
    input  wire logic [INDEX_W-1:0] i_point_index,
    input  wire logic [VALUE_W-1:0] i_value,
    output logic                    o_cmd_valid,
    input  wire logic               i_cmd_take,
    output t_cmd                    o_cmd
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_cnt;
    logic             push, pop, drop;

    assign o_stall     = (r_cnt == (PTR_W+1)'(QUEUE_DEPTH));
    // drop writes aimed past the last point
    assign drop        = i_kind && (int'(i_point_index) >= CAL_POINTS);
    assign push        = i_valid && !o_stall && !drop;
    assign pop         = o_cmd_valid && i_cmd_take;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
        if (push) r_mem[r_wr] <= '{is_write: i_kind, point_index: i_point_index,
                                   value: i_value};
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PTR_W+1)'(QUEUE_DEPTH)) else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !pop) else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 1'b1)) else $error("count slip");
endmodule
`default_nettype wire

>>> rtl/cti_back.sv
`default_nettype none
module cti_back
    import cti_pkg::*;
#(
    parameter int CAL_POINTS = CAL_POINTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_valid,
    output logic                   o_cmd_take,
    input  wire t_cmd              i_cmd,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [FLOW_W-1:0]      o_flow_halves,
    output logic [STATUS_W-1:0]    o_range_status
);
    localparam int ENTRIES = 2*CAL_POINTS - 1;
    localparam int IDX_W   = $clog2(ENTRIES + 1);
    localparam int TAB_W   = $clog2(ENTRIES);
    localparam int FLOW_MAX = ENTRIES - 1 + FLOW_OFFSET;
    // numerator width: (ENTRIES+4)*4095 scaled by 2, plus margin
    localparam int NUM_W = VALUE_W + IDX_W + 3;
    localparam int DEN_W = VALUE_W + 1;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PREP, S_DIV, S_FIX, S_DONE} t_state;

    t_state             r_state;
    logic [VALUE_W-1:0] r_tab [ENTRIES];
    logic [VALUE_W-1:0] r_x;
    logic [IDX_W-1:0]   r_k, r_lo, r_hi;
    logic               r_lo_ok, r_hi_ok;
    logic [VALUE_W-1:0] r_tl, r_tu;
    logic [NUM_W-1:0]   r_rem, r_quo;
    logic [DEN_W-1:0]   r_den;
    logic [$clog2(NUM_W+1)-1:0] r_bit;
    logic               r_valid;
    logic [FLOW_W-1:0]  r_flow;
    t_status            r_status;
    logic [FLOW_W-1:0]  r_out_flow;
    t_status            r_out_status;

    logic [VALUE_W-1:0] t;
    logic [IDX_W-1:0]   e;
    logic [TAB_W-1:0]   w_at, w_dn1, w_dn2, w_up1, w_up2;
    logic [VALUE_W:0]   d;
    logic [NUM_W-1:0]   span;
    logic [NUM_W-1:0]   num;
    logic [NUM_W:0]     trial;
    logic               out_free;

    assign out_free   = !r_valid || !i_stall;
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
    assign t          = r_tab[r_k[TAB_W-1:0]];
    assign e          = IDX_W'({i_cmd.point_index, 1'b0});
    assign w_at       = e[TAB_W-1:0];
    assign w_dn1      = w_at - TAB_W'(1);
    assign w_dn2      = w_at - TAB_W'(2);
    assign w_up1      = w_at + TAB_W'(1);
    assign w_up2      = w_at + TAB_W'(2);
    assign d          = {1'b0, r_tu} - {1'b0, r_tl};
    // hi may sit below lo when the table is not monotonic
    assign span       = NUM_W'($signed({1'b0, r_hi}) - $signed({1'b0, r_lo}));
    // 2N + D, N = (lo+4)*D + (x-tl)*(hi-lo)
    assign num = NUM_W'(2 * ((NUM_W'(r_lo) + NUM_W'(FLOW_OFFSET)) * NUM_W'(d)
                 + NUM_W'(r_x - r_tl) * span) + NUM_W'(d));
    assign trial = {r_rem[NUM_W-1:0], r_quo[NUM_W-1]} - (NUM_W+1)'({r_den, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) r_tab[i] <= '0;
        end else begin
            if (r_state == S_DONE && out_free) r_valid <= 1'b1;
            else if (!i_stall)                 r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.is_write) begin
                            r_tab[w_at] <= i_cmd.value;
                            if (e >= IDX_W'(2))
                                r_tab[w_dn1] <= VALUE_W'(
                                    ({1'b0, r_tab[w_dn2]} + {1'b0, i_cmd.value}) >> 1);
                            if (32'(e) + 2 < ENTRIES)
                                r_tab[w_up1] <= VALUE_W'(
                                    ({1'b0, r_tab[w_up2]} + {1'b0, i_cmd.value}) >> 1);
                        end else begin
                            r_x     <= i_cmd.value;
                            r_k     <= '0;
                            r_lo_ok <= 1'b0;
                            r_hi_ok <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (t <= r_x && (!r_lo_ok || t > r_tl)) begin
                        r_lo <= r_k; r_tl <= t; r_lo_ok <= 1'b1;
                    end
                    if (t >= r_x && (!r_hi_ok || t < r_tu)) begin
                        r_hi <= r_k; r_tu <= t; r_hi_ok <= 1'b1;
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == IDX_W'(ENTRIES - 1)) r_state <= S_PREP;
                end
                S_PREP: begin
                    if (!r_lo_ok) begin
                        r_flow <= FLOW_W'(FLOW_OFFSET); r_status <= ST_BELOW;
                        r_state <= S_DONE;
                    end else if (!r_hi_ok) begin
                        r_flow <= FLOW_W'(FLOW_MAX); r_status <= ST_ABOVE;
                        r_state <= S_DONE;
                    end else if (d == '0) begin
                        r_flow <= FLOW_W'(32'(r_lo) + FLOW_OFFSET);
                        r_status <= ST_INSIDE; r_state <= S_DONE;
                    end else begin
                        r_quo <= num; r_rem <= '0; r_den <= DEN_W'(d);
                        r_bit <= '0; r_status <= ST_INSIDE; r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // one restoring step a cycle, divisor 2D
                    if (!trial[NUM_W]) begin
                        r_rem <= trial[NUM_W-1:0];
                        r_quo <= {r_quo[NUM_W-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[NUM_W-2:0], r_quo[NUM_W-1]};
                        r_quo <= {r_quo[NUM_W-2:0], 1'b0};
                    end
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == $bits(r_bit)'(NUM_W - 1)) r_state <= S_FIX;
                end
                S_FIX: begin
                    r_flow  <= (r_quo > NUM_W'(FLOW_MAX)) ? FLOW_W'(FLOW_MAX) :
                               FLOW_W'(r_quo);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out_flow   <= r_flow;
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_flow_halves  = r_out_flow;
    assign o_range_status = r_out_status;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !o_cmd_take) else $error("take while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_flow_halves >= FLOW_W'(FLOW_OFFSET))) else $error("flow low");
endmodule
`default_nettype wire

>>> rtl/calibration_table_interpolator_unit.sv
// Channel | valid   | stall   | payload
// input   | i_valid | o_stall | i_kind, i_point_index, i_value
// output  | o_valid | i_stall | o_flow_halves, o_range_status
// A write is done in the back end's idle state and gives no item.
// A lookup scans every table entry, then runs the bit-serial divide when it
// falls inside the table; the back end takes no new command until the
// result moves into the output register.
// A two-entry queue keeps accepting while the back end works, until it is full.
// Synchronous reset clears the table to zero and empties the queue.
`default_nettype none
module calibration_table_interpolator_unit
    import cti_pkg::*;
#(
    parameter int CAL_POINTS = CAL_POINTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic                i_kind,
    input  wire logic [INDEX_W-1:0]  i_point_index,
    input  wire logic [VALUE_W-1:0]  i_value,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [FLOW_W-1:0]        o_flow_halves,
    output logic [STATUS_W-1:0]      o_range_status
);
    t_cmd cmd;
    logic cmd_valid, cmd_take;

    cti_front #(.CAL_POINTS(CAL_POINTS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_kind, .i_point_index, .i_value,
        .o_cmd_valid(cmd_valid), .i_cmd_take(cmd_take), .o_cmd(cmd)
    );

    cti_back #(.CAL_POINTS(CAL_POINTS)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_take(cmd_take),
        .i_cmd(cmd), .o_valid, .i_stall, .o_flow_halves, .o_range_status
    );
endmodule
`default_nettype wire
